// ----- sv/ordered_list_engine_defines.svh -----
// ----------------------------------------------------------------------------
// ordered list engine assertion macros
// concurrent checks on clk_i with rst_ni low holding them off
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every edge
`define OLE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ordered list engine check failed");
// consequence in the cycle after the antecedent
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ordered list engine check failed");
`else
`define OLE_ASSERT(lbl, prop)
`define OLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- sv/olist_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg
// shared sizes, request codes and control structs of the ordered list engine
// ----------------------------------------------------------------------------
package olist_pkg;

  // list sizing
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned WIDE_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  // result field widths
  localparam int unsigned MIDX_W   = 4;
  localparam int unsigned MCNT_W   = 5;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_POP_FRONT  = 3'd1,
    REQ_PUSH_BACK  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_INSERT     = 3'd4,
    REQ_REMOVE     = 3'd5,
    REQ_REVERSE    = 3'd6,
    REQ_FIND       = 3'd7
  } req_e;

  // per-cell update kind
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  // top level sequencer
  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e                  op;
    logic [IDX_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

  // captured request
  typedef struct packed {
    req_e                      kind;
    logic signed [DATA_W-1:0]  value;
    logic [POS_W-1:0]          pos;
  } req_t;

  // result of one request
  typedef struct packed {
    logic                      found;
    logic [MIDX_W-1:0]         index;
    logic [MCNT_W-1:0]         count;
    logic                      rejected;
  } res_t;

  // list bookkeeping update
  typedef struct packed {
    logic [CNT_W-1:0]          count;
    logic                      rev;
  } upd_t;

endpackage

// ----- sv/olist_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_cell
// one storage cell: holds a value, shifts to or from its neighbors, compares
// ----------------------------------------------------------------------------
module olist_cell (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [olist_pkg::IDX_W-1:0]           idx_i,
  input  logic [olist_pkg::CNT_W-1:0]           count_i,
  input  olist_pkg::cell_ctrl_t                 ctrl_i,
  input  logic                                  cmp_en_i,
  input  logic signed [olist_pkg::DATA_W-1:0]   cmp_val_i,
  input  logic signed [olist_pkg::DATA_W-1:0]   lower_i,
  input  logic signed [olist_pkg::DATA_W-1:0]   upper_i,
  output logic signed [olist_pkg::DATA_W-1:0]   value_o,
  output logic                                  match_o
);

  logic signed [olist_pkg::DATA_W-1:0] value_q, value_d;
  logic                                match_q, match_d;
  logic                                occupied;

  // cell holds a live entry
  assign occupied = olist_pkg::CNT_W'(idx_i) < count_i;

  // shift or load
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      olist_pkg::CELL_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          value_d = lower_i;
        end else if (idx_i == ctrl_i.pos) begin
          value_d = ctrl_i.value;
        end
      end
      olist_pkg::CELL_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          value_d = upper_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // compare against the incoming request value
  assign match_d = cmp_en_i ? (occupied && (value_q == cmp_val_i)) : match_q;

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign value_o = value_q;
  assign match_o = match_q;

endmodule

// ----- sv/olist_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_ctrl
// maps a logical request onto the physical cell row and builds the result
// ----------------------------------------------------------------------------
module olist_ctrl (
  input  olist_pkg::req_t                       req_i,
  input  logic [olist_pkg::CNT_W-1:0]           count_i,
  input  logic                                  rev_i,
  input  logic [olist_pkg::CAPACITY-1:0]        match_i,
  output olist_pkg::cell_ctrl_t                 ctrl_o,
  output olist_pkg::upd_t                       upd_o,
  output olist_pkg::res_t                       res_o
);

  localparam int unsigned CW = olist_pkg::CNT_W;
  localparam int unsigned WW = olist_pkg::WIDE_W;
  localparam int unsigned IW = olist_pkg::IDX_W;

  logic          full;
  logic          pos_in_list;
  logic [CW-1:0] pos_clamp;
  logic [CW-1:0] ins_lp;
  logic [CW-1:0] rem_lp;
  logic [CW-1:0] ins_q;
  logic [CW-1:0] rem_q;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic [CW-1:0] find_idx;

  // list occupancy checks
  assign full        = count_i >= CW'(olist_pkg::CAPACITY);
  assign pos_in_list = WW'(req_i.pos) < WW'(count_i);
  assign pos_clamp   = pos_in_list ? CW'(req_i.pos) : count_i;

  // logical position of an insert or remove
  always_comb begin
    ins_lp = '0;
    rem_lp = '0;
    case (req_i.kind)
      olist_pkg::REQ_PUSH_BACK: ins_lp = count_i;
      olist_pkg::REQ_INSERT:    ins_lp = pos_clamp;
      olist_pkg::REQ_POP_BACK:  rem_lp = count_i - CW'(1);
      olist_pkg::REQ_REMOVE:    rem_lp = pos_clamp;
      default: begin
        ins_lp = '0;
        rem_lp = '0;
      end
    endcase
  end

  // physical position, mirrored while the row reads backwards
  assign ins_q = rev_i ? (count_i - ins_lp) : ins_lp;
  assign rem_q = rev_i ? (count_i - CW'(1) - rem_lp) : rem_lp;

  // first match in logical order
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < olist_pkg::CAPACITY; i++) begin
      if (match_i[i] && (rev_i || !hit)) begin
        hit_idx = IW'(i);
      end
      if (match_i[i]) begin
        hit = 1'b1;
      end
    end
  end

  assign find_idx = rev_i ? (count_i - CW'(1) - CW'(hit_idx)) : CW'(hit_idx);

  // request decode
  always_comb begin
    ctrl_o.op    = olist_pkg::CELL_HOLD;
    ctrl_o.pos   = '0;
    ctrl_o.value = req_i.value;
    upd_o.count  = count_i;
    upd_o.rev    = rev_i;
    res_o.found    = 1'b0;
    res_o.index    = '0;
    res_o.rejected = 1'b0;
    unique case (req_i.kind) inside
      olist_pkg::REQ_PUSH_FRONT,
      olist_pkg::REQ_PUSH_BACK,
      olist_pkg::REQ_INSERT: begin
        if (full) begin
          res_o.rejected = 1'b1;
        end else begin
          ctrl_o.op   = olist_pkg::CELL_INSERT;
          ctrl_o.pos  = IW'(ins_q);
          upd_o.count = count_i + CW'(1);
        end
      end
      olist_pkg::REQ_POP_FRONT,
      olist_pkg::REQ_POP_BACK: begin
        if (count_i != '0) begin
          ctrl_o.op   = olist_pkg::CELL_REMOVE;
          ctrl_o.pos  = IW'(rem_q);
          upd_o.count = count_i - CW'(1);
        end
      end
      olist_pkg::REQ_REMOVE: begin
        if (pos_in_list) begin
          ctrl_o.op   = olist_pkg::CELL_REMOVE;
          ctrl_o.pos  = IW'(rem_q);
          upd_o.count = count_i - CW'(1);
        end
      end
      olist_pkg::REQ_REVERSE: begin
        upd_o.rev = !rev_i;
      end
      olist_pkg::REQ_FIND: begin
        if (hit) begin
          res_o.found = 1'b1;
          res_o.index = olist_pkg::MIDX_W'(find_idx);
        end
      end
      default: begin
        upd_o.count = count_i;
      end
    endcase
    res_o.count = olist_pkg::MCNT_W'(upd_o.count);
  end

endmodule

// ----- sv/ordered_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// ordered list of signed words kept in a row of shifting compare cells
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (lsb first)                   | tuser
//  s_axis   | in        | item_value[31:0] slot_position[39:32] | req_type[2:0]
//  m_axis   | out       | match_found[0] match_index[4:1]       | -
//           |           | entry_count[9:5] push_rejected[10]    |
//
// on accepting a request every cell compares its word with item_value, and
// once the apply state goes ahead, the row shifts and the result loads
// into the output register. reverse flips a direction bit instead of moving
// data. a new request is taken while a result waits; the apply cycle stalls
// only while the output register is still full. reset empties the list.
// ----------------------------------------------------------------------------
`include "ordered_list_engine_defines.svh"

module ordered_list_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value, slot_position
  input  logic [2:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // match_found, match_index, entry_count,
                                      // push_rejected
);

  localparam int unsigned N  = olist_pkg::CAPACITY;
  localparam int unsigned DW = olist_pkg::DATA_W;

  olist_pkg::state_e     state_q, state_d;
  olist_pkg::req_t       req_q, req_d;
  logic [olist_pkg::CNT_W-1:0] count_q, count_d;
  logic                  rev_q, rev_d;
  logic                  out_valid_q, out_valid_d;
  olist_pkg::res_t       res_q, res_d;

  logic                  in_fire;
  logic                  apply;
  olist_pkg::cell_ctrl_t dec_ctrl;
  olist_pkg::cell_ctrl_t cell_ctrl;
  olist_pkg::upd_t       upd;
  olist_pkg::res_t       res_new;

  logic signed [DW-1:0]  cell_val [N];
  logic [N-1:0]          match;

  // sequencer
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    apply         = 1'b0;
    unique case (state_q)
      olist_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = olist_pkg::ST_APPLY;
        end
      end
      olist_pkg::ST_APPLY: begin
        if (!out_valid_q || m_axis_tready) begin
          apply   = 1'b1;
          state_d = olist_pkg::ST_IDLE;
        end
      end
      default: state_d = olist_pkg::ST_IDLE;
    endcase
  end

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // request capture
  always_comb begin
    req_d = req_q;
    if (in_fire) begin
      req_d.kind  = olist_pkg::req_e'(s_axis_tuser);
      req_d.value = s_axis_tdata[31:0];
      req_d.pos   = s_axis_tdata[39:32];
    end
  end

  // request decode
  olist_ctrl u_ctrl (
    .req_i   (req_q),
    .count_i (count_q),
    .rev_i   (rev_q),
    .match_i (match),
    .ctrl_o  (dec_ctrl),
    .upd_o   (upd),
    .res_o   (res_new)
  );

  // cells only move on the apply cycle
  always_comb begin
    cell_ctrl = dec_ctrl;
    if (!apply) begin
      cell_ctrl.op = olist_pkg::CELL_HOLD;
    end
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic signed [DW-1:0] lower;
    logic signed [DW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = req_q.value;
    end else begin : g_mid_lo
      assign lower = cell_val[i-1];
    end
    if (i == N - 1) begin : g_last
      assign upper = cell_val[i];
    end else begin : g_mid_hi
      assign upper = cell_val[i+1];
    end
    olist_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (olist_pkg::IDX_W'(i)),
      .count_i   (count_q),
      .ctrl_i    (cell_ctrl),
      .cmp_en_i  (in_fire),
      .cmp_val_i (s_axis_tdata[31:0]),
      .lower_i   (lower),
      .upper_i   (upper),
      .value_o   (cell_val[i]),
      .match_o   (match[i])
    );
  end

  // list bookkeeping and output register
  always_comb begin
    count_d     = count_q;
    rev_d       = rev_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (apply) begin
      count_d     = upd.count;
      rev_d       = upd.rev;
      res_d       = res_new;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::ST_IDLE;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.rejected, res_q.count, res_q.index, res_q.found};

  // checks
  `OLE_ASSERT(a_count_bound, count_q <= olist_pkg::CNT_W'(olist_pkg::CAPACITY))
  `OLE_ASSERT_NEXT(a_accept_to_apply, in_fire, state_q == olist_pkg::ST_APPLY)
  `OLE_ASSERT(a_reject_full, !(out_valid_q && res_q.rejected) || (count_q == olist_pkg::CNT_W'(N)))
  `OLE_ASSERT(a_found_nonempty, !(out_valid_q && res_q.found) || (count_q != '0))

endmodule

// ----- verif/ordered_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_checker
// watches both stream channels of the ordered list engine, keeps a shadow
// copy of the list, predicts one result per accepted request and compares it
// field by field with the results the engine hands out, in order
// ----------------------------------------------------------------------------
module ordered_list_checker
  import olist_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // item_value, slot_position
  input  logic [2:0]  s_axis_tuser,   // req_type
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // match_found, match_index, entry_count,
                                      // push_rejected
  output int          pending_o,
  output int          errors_o
);

  localparam int MAX_REPORTS = 40;

  // shadow list, front at index 0
  logic signed [DATA_W-1:0] shadow_list[$];
  // results predicted but not yet seen
  res_t                     pending_results[$];
  int                       fail_cnt;
  res_t                     want;
  res_t                     got;

  // apply one request to the shadow list and return its result
  function automatic res_t next_list_result(req_e kind, logic signed [DATA_W-1:0] value,
                                            logic [POS_W-1:0] pos);
    res_t                     r;
    logic signed [DATA_W-1:0] tmp;
    int                       lo;
    int                       hi;
    bit                       full;
    r    = '0;
    full = (shadow_list.size() >= CAPACITY);
    case (kind)
      REQ_PUSH_FRONT: begin
        if (full) r.rejected = 1'b1;
        else shadow_list.push_front(value);
      end
      REQ_POP_FRONT: begin
        if (shadow_list.size() > 0) void'(shadow_list.pop_front());
      end
      REQ_PUSH_BACK: begin
        if (full) r.rejected = 1'b1;
        else shadow_list.push_back(value);
      end
      REQ_POP_BACK: begin
        if (shadow_list.size() > 0) void'(shadow_list.pop_back());
      end
      REQ_INSERT: begin
        // a position at or past the end appends
        if (full) r.rejected = 1'b1;
        else if (pos < shadow_list.size()) shadow_list.insert(pos, value);
        else shadow_list.push_back(value);
      end
      REQ_REMOVE: begin
        if (pos < shadow_list.size()) shadow_list.delete(pos);
      end
      REQ_REVERSE: begin
        lo = 0;
        hi = shadow_list.size() - 1;
        while (lo < hi) begin
          tmp             = shadow_list[lo];
          shadow_list[lo] = shadow_list[hi];
          shadow_list[hi] = tmp;
          lo++;
          hi--;
        end
      end
      REQ_FIND: begin
        // first equal value wins
        for (int k = 0; k < shadow_list.size(); k++) begin
          if (!r.found && shadow_list[k] == value) begin
            r.found = 1'b1;
            r.index = MIDX_W'(k);
          end
        end
      end
      default: ;
    endcase
    r.count = MCNT_W'(shadow_list.size());
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
    end
  endtask

  // compare outgoing results first, then predict the incoming request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_list.delete();
      pending_results.delete();
      fail_cnt = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found    = m_axis_tdata[0];
        got.index    = m_axis_tdata[4:1];
        got.count    = m_axis_tdata[9:5];
        got.rejected = m_axis_tdata[10];
        if (pending_results.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual %h", $time,
                     m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("match_found", want.found, got.found);
          check_field("match_index", want.index, got.index);
          check_field("entry_count", want.count, got.count);
          check_field("push_rejected", want.rejected, got.rejected);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results.push_back(next_list_result(req_e'(s_axis_tuser),
                                                   s_axis_tdata[31:0],
                                                   s_axis_tdata[39:32]));
      pending_o <= pending_results.size();
      errors_o  <= fail_cnt;
    end
  end

endmodule

// ----- verif/tb_ordered_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// drives list requests into the ordered list engine: a directed opening over
// empty-list, extreme-value and position corner cases, then random bursts
// that grow, shrink or stir the list, with random gaps on both channels, a
// stretch without gaps and one long output stall. a checker beside the
// engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;
  import olist_pkg::*;

  localparam int RANDOM_ITEMS   = 1230;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_AT_ITEM   = 700;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum int {
    BURST_GROW,
    BURST_SHRINK,
    BURST_STIR
  } burst_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // item_value, slot_position
  logic [2:0]  s_axis_tuser;   // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // match_found, match_index, entry_count,
                               // push_rejected
  int          pending;
  int          errors;

  int                       sent_count;
  bit                       steady;
  int                       quiet_cycles;
  logic signed [DATA_W-1:0] value_pool[8];

  ordered_list_engine uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ordered_list_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // offer one request and wait until it is taken
  task automatic send_request(req_e kind, logic signed [DATA_W-1:0] value,
                              logic [POS_W-1:0] pos);
    if (!steady) begin
      while ($urandom_range(0, 99) < 31) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pos, value};
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_count++;
  endtask

  // values repeat often so that finds hit and duplicates occur
  function automatic logic signed [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // positions mostly near the list, sometimes anywhere in the field
  function automatic logic [POS_W-1:0] pick_pos();
    if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 255));
    return POS_W'($urandom_range(0, CAPACITY + 1));
  endfunction

  function automatic req_e pick_kind(burst_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    if (mode == BURST_GROW && roll < 75) begin
      case ($urandom_range(0, 2))
        0:       return REQ_PUSH_FRONT;
        1:       return REQ_PUSH_BACK;
        default: return REQ_INSERT;
      endcase
    end
    if (mode == BURST_SHRINK && roll < 65) begin
      case ($urandom_range(0, 2))
        0:       return REQ_POP_FRONT;
        1:       return REQ_POP_BACK;
        default: return REQ_REMOVE;
      endcase
    end
    return req_e'($urandom_range(0, 7));
  endfunction

  // output side: random stalls, a gap-free stretch and one long hold-off
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && sent_count >= HOLD_AT_ITEM) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (steady) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 31);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ordered_list_engine test failed");
      $finish;
    end
  end

  // request stream and verdict
  initial begin
    burst_e mode;
    int     burst_len;
    int     n;
    sent_count   = 0;
    steady       = 1'b0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    value_pool[4] = 32'sd1;
    for (int k = 5; k < 8; k++) value_pool[k] = $urandom;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_PUSH_FRONT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // requests on an empty list do nothing
    send_request(REQ_FIND,       32'sd0, 8'd0);
    send_request(REQ_POP_FRONT,  32'sd0, 8'd0);
    send_request(REQ_POP_BACK,   32'sd0, 8'd0);
    send_request(REQ_REMOVE,     32'sd0, 8'd0);
    send_request(REQ_REVERSE,    32'sd0, 8'd0);
    // extremes, single-entry reverse, inserts at front, middle and past end
    send_request(REQ_PUSH_FRONT, 32'sh8000_0000, 8'd0);
    send_request(REQ_REVERSE,    32'sd0, 8'd0);
    send_request(REQ_PUSH_BACK,  32'sh7FFF_FFFF, 8'd255);
    send_request(REQ_INSERT,     -32'sd1, 8'd255);
    send_request(REQ_INSERT,     32'sd0, 8'd0);
    send_request(REQ_INSERT,     32'sd1, 8'd2);
    send_request(REQ_FIND,       32'sh7FFF_FFFF, 8'd0);
    send_request(REQ_PUSH_BACK,  32'sd1, 8'd0);
    send_request(REQ_FIND,       32'sd1, 8'd0);
    send_request(REQ_REVERSE,    32'sd0, 8'd0);
    send_request(REQ_FIND,       32'sh8000_0000, 8'd0);
    // remove past end, in the middle, then both ends
    send_request(REQ_REMOVE,     32'sd0, 8'd255);
    send_request(REQ_REMOVE,     32'sd0, 8'd1);
    send_request(REQ_POP_FRONT,  32'sd0, 8'd0);
    send_request(REQ_POP_BACK,   32'sd0, 8'd0);
    send_request(REQ_FIND,       32'sd12345, 8'd0);

    // random bursts, the first one growing the list
    n    = 0;
    mode = BURST_GROW;
    while (n < RANDOM_ITEMS) begin
      burst_len = $urandom_range(10, 40);
      for (int i = 0; i < burst_len && n < RANDOM_ITEMS; i++) begin
        steady = (n >= 400 && n < 600);
        if ($urandom_range(0, 15) == 0) value_pool[$urandom_range(2, 7)] = $urandom;
        send_request(pick_kind(mode), pick_value(), pick_pos());
        n++;
      end
      mode = burst_e'($urandom_range(0, 2));
    end
    s_axis_tvalid <= 1'b0;
    steady = 1'b0;

    // drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("ordered_list_engine test passed");
    else
      $display("ordered_list_engine test failed");
    $finish;
  end

endmodule
